@@ rtl/gfmi_pkg.sv @@
// Package for the GF(2^n) multiply and inverse unit.
// Holds the shared constants, the operation code and the core control word.
// No dependencies.
`default_nettype none

package gfmi_pkg;

    localparam int unsigned OPERAND_BITS       = 8;
    localparam int unsigned FIELD_BITS_DEFAULT = 8;
    localparam logic [OPERAND_BITS-1:0] POLY_RESET = 8'h1B;

    typedef enum logic [0:0] {
        OP_MUL = 1'b0,
        OP_INV = 1'b1
    } t_op;

    typedef struct packed {
        logic start;
        logic ack;
    } t_core_ctrl;

endpackage

`default_nettype wire

@@ rtl/gfmi_mul_core.sv @@
// Bit-serial GF(2^n) multiplier: one bit of the multiplier per cycle, MSB first.
// Depends on gfmi_pkg.
`default_nettype none

module gfmi_mul_core import gfmi_pkg::*; #(
    parameter int unsigned FIELD_BITS = FIELD_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_core_ctrl            i_ctrl,
    input  logic [FIELD_BITS-1:0] i_multiplicand,
    input  logic [FIELD_BITS-1:0] i_multiplier,
    input  logic [FIELD_BITS-1:0] i_poly_low,
    output logic                  o_done,
    output logic [FIELD_BITS-1:0] o_result
);

    localparam int unsigned W  = FIELD_BITS;
    localparam int unsigned CW = $clog2(W);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_mul_state;

    t_mul_state      r_state, n_state;
    logic [W-1:0]    r_acc, n_acc;
    logic [W-1:0]    r_a, n_a;
    logic [W-1:0]    r_b, n_b;
    logic [W-1:0]    r_low, n_low;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [W-1:0]    acc_dbl;

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_a     = r_a;
        n_b     = r_b;
        n_low   = r_low;
        n_cnt   = r_cnt;
        acc_dbl = {r_acc[W-2:0], 1'b0} ^ (r_acc[W-1] ? r_low : '0);
        case (r_state)
            S_IDLE: begin
                if (i_ctrl.start) begin
                    n_acc   = '0;
                    n_a     = i_multiplicand;
                    n_b     = i_multiplier;
                    n_low   = i_poly_low;
                    n_cnt   = CW'(W - 1);
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_acc = acc_dbl ^ (r_b[W-1] ? r_a : '0);
                n_b   = {r_b[W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ctrl.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_low <= n_low;
        r_cnt <= n_cnt;
    end

    assign o_done   = (r_state == S_DONE);
    assign o_result = r_acc;

endmodule

`default_nettype wire

@@ rtl/gfmi_inv_core.sv @@
// Extended Euclidean inverter over GF(2^n): normalise and long-division steps,
// one shift-subtract per cycle on left-aligned remainders. Depends on gfmi_pkg.
`default_nettype none

module gfmi_inv_core import gfmi_pkg::*; #(
    parameter int unsigned FIELD_BITS = FIELD_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_core_ctrl            i_ctrl,
    input  logic [FIELD_BITS-1:0] i_operand,
    input  logic [FIELD_BITS-1:0] i_poly_low,
    output logic                  o_done,
    output logic [FIELD_BITS-1:0] o_result
);

    localparam int unsigned W  = FIELD_BITS;
    localparam int unsigned DW = $clog2(W + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_NORM = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_inv_state;

    t_inv_state    r_state, n_state;
    logic [W:0]    r_r0, n_r0;
    logic [W:0]    r_r1, n_r1;
    logic [W:0]    r_t0, n_t0;
    logic [W:0]    r_t1, n_t1;
    logic [W:0]    r_m, n_m;
    logic [DW-1:0] r_d0, n_d0;
    logic [DW-1:0] r_d1, n_d1;
    logic [W-1:0]  r_result, n_result;
    logic          q_bit;
    logic [W:0]    r0_sub;
    logic [W:0]    r0_shl;
    logic [W:0]    m_shl;

    always_comb begin
        n_state  = r_state;
        n_r0     = r_r0;
        n_r1     = r_r1;
        n_t0     = r_t0;
        n_t1     = r_t1;
        n_m      = r_m;
        n_d0     = r_d0;
        n_d1     = r_d1;
        n_result = r_result;
        q_bit    = r_r0[W];
        r0_sub   = q_bit ? (r_r0 ^ r_r1) : r_r0;
        r0_shl   = {r0_sub[W-1:0], 1'b0};
        m_shl    = {r_m[W-1:0], 1'b0} ^ (q_bit ? r_t1 : '0);
        case (r_state)
            S_IDLE: begin
                if (i_ctrl.start) begin
                    if (i_operand == '0) begin
                        n_result = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_r0    = {1'b1, i_poly_low};
                        n_d0    = DW'(W);
                        n_r1    = {1'b0, i_operand};
                        n_d1    = DW'(W);
                        n_t0    = '0;
                        n_t1    = {{W{1'b0}}, 1'b1};
                        n_state = S_NORM;
                    end
                end
            end
            S_NORM: begin
                if (r_r1 == '0) begin
                    // The divisor is exhausted: the gcd is a unit only at degree zero.
                    n_result = (r_d0 == '0) ? r_t0[W-1:0] : '0;
                    n_state  = S_DONE;
                end else if (r_r1[W]) begin
                    n_m     = '0;
                    n_state = S_DIV;
                end else begin
                    n_r1 = {r_r1[W-1:0], 1'b0};
                    n_d1 = r_d1 - 1'b1;
                end
            end
            S_DIV: begin
                if (r_d0 == r_d1) begin
                    n_r0    = r_r1;
                    n_d0    = r_d1;
                    n_r1    = r0_shl;
                    n_d1    = r_d1 - 1'b1;
                    n_t0    = r_t1;
                    n_t1    = r_t0 ^ m_shl;
                    n_state = S_NORM;
                end else begin
                    n_r0 = r0_shl;
                    n_m  = m_shl;
                    n_d0 = r_d0 - 1'b1;
                end
            end
            S_DONE: begin
                if (i_ctrl.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r0     <= n_r0;
        r_r1     <= n_r1;
        r_t0     <= n_t0;
        r_t1     <= n_t1;
        r_m      <= n_m;
        r_d0     <= n_d0;
        r_d1     <= n_d1;
        r_result <= n_result;
    end

    assign o_done   = (r_state == S_DONE);
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_div_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_d0 >= r_d1))
        else $error("division step with dividend degree below divisor degree");

    a_div_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_r1[W])
        else $error("division step with an unnormalised divisor");

    a_norm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM && r_r1 != '0 && !r_r1[W]) |-> (r_d1 != '0))
        else $error("normalisation would take the degree below zero");
`endif

endmodule

`default_nettype wire

@@ rtl/gf256_multiply_inverse_unit.sv @@
// GF(2^n) multiply and inverse unit: handshake, configuration register, output register.
// Instantiates gfmi_mul_core and gfmi_inv_core; depends on gfmi_pkg.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one word: an operation code and two
//   operands. Output channel (o_valid / i_ready) carries one result word.
//   One word is worked on at a time. A multiply works one multiplier bit per
//   cycle. An inverse runs the normalise and shift-subtract steps of the
//   Euclidean sequencer, one per cycle; the inverse of zero goes straight to
//   done. The next word is accepted in the cycle after its predecessor's result
//   is registered. The result is held in an output register, so the next word is
//   accepted while an earlier result still waits. If the receiver stalls, the
//   finished core holds its result until the output register is free again.
//   The reduction polynomial register is written through i_cfg_we / i_cfg_wdata;
//   it is to be written only while the unit is idle, which the unit itself does
//   not enforce. Reset clears the busy and output valid flags and the core
//   states and loads the polynomial x^8 + x^4 + x^3 + x + 1.
`default_nettype none

module gf256_multiply_inverse_unit import gfmi_pkg::*; #(
    parameter int unsigned FIELD_BITS = FIELD_BITS_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_operation,
    input  logic [OPERAND_BITS-1:0] i_first_operand,
    input  logic [OPERAND_BITS-1:0] i_second_operand,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [OPERAND_BITS-1:0] o_field_result,
    input  logic                    i_cfg_we,
    input  logic [OPERAND_BITS-1:0] i_cfg_wdata
);

    localparam int unsigned W  = FIELD_BITS;
    localparam int unsigned CW = (W < OPERAND_BITS) ? W : OPERAND_BITS;

    logic                    r_busy;
    t_op                     r_op;
    logic [OPERAND_BITS-1:0] r_poly;
    logic                    r_out_valid;
    logic [OPERAND_BITS-1:0] r_result;

    logic         in_accept;
    logic         out_free;
    logic         res_done;
    logic         res_take;
    logic [W-1:0] res_value;
    logic [W-1:0] op_a;
    logic [W-1:0] op_b;
    logic [W-1:0] poly_low;
    logic         mul_done;
    logic         inv_done;
    logic [W-1:0] mul_result;
    logic [W-1:0] inv_result;
    t_core_ctrl   mul_ctrl;
    t_core_ctrl   inv_ctrl;

    assign op_a     = W'(i_first_operand[CW-1:0]);
    assign op_b     = W'(i_second_operand[CW-1:0]);
    assign poly_low = W'(r_poly[CW-1:0]);

    assign o_ready   = !r_busy;
    assign in_accept = i_valid && !r_busy;
    assign out_free  = !r_out_valid || i_ready;
    assign res_done  = (r_op == OP_MUL) ? mul_done : inv_done;
    assign res_value = (r_op == OP_MUL) ? mul_result : inv_result;
    assign res_take  = r_busy && res_done && out_free;

    assign mul_ctrl = '{start: in_accept && (t_op'(i_operation) == OP_MUL),
                        ack:   res_take && (r_op == OP_MUL)};
    assign inv_ctrl = '{start: in_accept && (t_op'(i_operation) == OP_INV),
                        ack:   res_take && (r_op == OP_INV)};

    gfmi_mul_core #(
        .FIELD_BITS (FIELD_BITS)
    ) u_mul (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (mul_ctrl),
        .i_multiplicand (op_a),
        .i_multiplier   (op_b),
        .i_poly_low     (poly_low),
        .o_done         (mul_done),
        .o_result       (mul_result)
    );

    gfmi_inv_core #(
        .FIELD_BITS (FIELD_BITS)
    ) u_inv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (inv_ctrl),
        .i_operand  (op_a),
        .i_poly_low (poly_low),
        .o_done     (inv_done),
        .o_result   (inv_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_poly      <= POLY_RESET;
        end else begin
            if (in_accept) begin
                r_busy <= 1'b1;
            end else if (res_take) begin
                r_busy <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= res_take;
            end
            if (i_cfg_we) begin
                r_poly <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op <= t_op'(i_operation);
        end
        if (res_take) begin
            r_result <= OPERAND_BITS'(res_value);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_field_result = r_result;

endmodule

`default_nettype wire
